// File: src/sbf_pkg.sv
`default_nettype none
package sbf_pkg;

  localparam logic [7:0] END_TYPE = 8'd127;
  localparam logic [7:0] HDR_SIZE = 8'd4;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_AREA = 3'd1,
    PH_SEC  = 3'd2,
    PH_LEAD = 3'd3,
    PH_STR  = 3'd4,
    PH_NUL  = 3'd5,
    PH_STOP = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_FMT  = 3'd0,
    ROLE_TEXT = 3'd1,
    ROLE_NUL  = 3'd2,
    ROLE_TERM = 3'd3,
    ROLE_IGN  = 3'd4,
    ROLE_LEAD = 3'd5
  } role_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  area_count;
    logic [7:0]  length;
    logic [7:0]  stype;
    logic [15:0] handle;
    logic [7:0]  string_count;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:        PH_HDR,
    area_count:   8'd0,
    length:       8'd0,
    stype:        8'd0,
    handle:       16'd0,
    string_count: 8'd0
  };

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  area_offset;
    logic [7:0]  string_number;
    logic [7:0]  struct_type;
    logic [15:0] struct_handle;
    logic [7:0]  struct_length;
    logic        header_ok;
    logic        struct_done;
    logic        struct_cut;
    logic        corrupt_stop;
    logic        table_end;
  } result_t;

endpackage
`default_nettype wire

// File: src/sbf_if.sv
`default_nettype none
interface sbf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       final_byte;

  modport source (output valid, output table_byte, output final_byte, input ready);
  modport sink   (input valid, input table_byte, input final_byte, output ready);
endinterface

interface sbf_role_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  area_offset;
  logic [7:0]  string_number;
  logic [7:0]  struct_type;
  logic [15:0] struct_handle;
  logic [7:0]  struct_length;
  logic        header_ok;
  logic        struct_done;
  logic        struct_cut;
  logic        corrupt_stop;
  logic        table_end;

  modport source (
    output valid, output byte_role, output area_offset, output string_number,
    output struct_type, output struct_handle, output struct_length,
    output header_ok, output struct_done, output struct_cut,
    output corrupt_stop, output table_end, input ready
  );
  modport sink (
    input valid, input byte_role, input area_offset, input string_number,
    input struct_type, input struct_handle, input struct_length,
    input header_ok, input struct_done, input struct_cut,
    input corrupt_stop, input table_end, output ready
  );
endinterface
`default_nettype wire

// File: src/sbf_step.sv
`default_nettype none
module sbf_step
  import sbf_pkg::*;
(
  input  parse_state_t cur,
  input  logic [7:0]   table_byte,
  input  logic         final_byte,
  output parse_state_t nxt,
  output result_t      res
);

  logic [7:0] cnt_inc;
  logic       done;
  logic       cut;
  logic       corr;
  logic       tend;
  role_t      role;
  logic [7:0] off;
  logic       hok;
  parse_state_t upd;

  assign cnt_inc = cur.area_count + 8'd1;

  always_comb begin
    upd  = cur;
    role = ROLE_IGN;
    off  = 8'd0;
    hok  = 1'b0;
    done = 1'b0;
    cut  = 1'b0;
    corr = 1'b0;
    tend = 1'b0;
    case (cur.phase)
      PH_HDR: begin
        role = ROLE_FMT;
        off  = cur.area_count;
        if (cur.area_count == 8'd0) begin
          upd.stype        = table_byte;
          upd.length       = 8'd0;
          upd.handle       = 16'd0;
          upd.string_count = 8'd0;
        end else if (cur.area_count == 8'd1) begin
          upd.length = table_byte;
        end else if (cur.area_count == 8'd2) begin
          upd.handle = {8'd0, table_byte};
        end else begin
          upd.handle = {table_byte, cur.handle[7:0]};
        end
        if (cur.area_count < HDR_SIZE - 8'd1) begin
          upd.area_count = cnt_inc;
        end else if (upd.length < HDR_SIZE) begin
          corr = 1'b1;
        end else if (upd.length == HDR_SIZE) begin
          hok       = 1'b1;
          upd.phase = PH_SEC;
          cut       = final_byte;
        end else begin
          upd.area_count = HDR_SIZE;
          upd.phase      = PH_AREA;
          corr           = final_byte;
        end
      end
      PH_AREA: begin
        role           = ROLE_FMT;
        off            = cur.area_count;
        upd.area_count = cnt_inc;
        if (cnt_inc == cur.length) begin
          hok       = 1'b1;
          upd.phase = PH_SEC;
          cut       = final_byte;
        end else begin
          corr = final_byte;
        end
      end
      PH_SEC: begin
        upd.string_count = 8'd1;
        if (table_byte == 8'd0) begin
          role      = ROLE_LEAD;
          upd.phase = PH_LEAD;
        end else begin
          role      = ROLE_TEXT;
          upd.phase = PH_STR;
        end
        cut = final_byte;
      end
      PH_LEAD: begin
        if (table_byte == 8'd0) begin
          role             = ROLE_TERM;
          upd.string_count = 8'd0;
          done             = 1'b1;
        end else begin
          role             = ROLE_TEXT;
          upd.string_count = 8'd2;
          upd.phase        = PH_STR;
          cut              = final_byte;
        end
      end
      PH_STR: begin
        if (table_byte == 8'd0) begin
          role      = ROLE_NUL;
          upd.phase = PH_NUL;
        end else begin
          role = ROLE_TEXT;
        end
        cut = final_byte;
      end
      PH_NUL: begin
        if (table_byte == 8'd0) begin
          role = ROLE_TERM;
          done = 1'b1;
        end else begin
          role = ROLE_TEXT;
          if (cur.string_count != 8'hFF) begin
            upd.string_count = cur.string_count + 8'd1;
          end
          upd.phase = PH_STR;
          cut       = final_byte;
        end
      end
      default: begin
        role = ROLE_IGN;
      end
    endcase
    if (done) begin
      tend           = (cur.stype == END_TYPE);
      upd.area_count = 8'd0;
      upd.phase      = tend ? PH_STOP : PH_HDR;
    end
    if (cut || corr) begin
      upd.phase = PH_STOP;
    end
  end

  assign res.byte_role     = role;
  assign res.area_offset   = off;
  assign res.string_number = upd.string_count;
  assign res.struct_type   = upd.stype;
  assign res.struct_handle = upd.handle;
  assign res.struct_length = upd.length;
  assign res.header_ok     = hok;
  assign res.struct_done   = done;
  assign res.struct_cut    = cut;
  assign res.corrupt_stop  = corr;
  assign res.table_end     = tend;

  assign nxt = final_byte ? STATE_RESET : upd;

endmodule
`default_nettype wire

// File: src/smbios_structure_framer.sv
`default_nettype none
// channel       dir  beat payload
// table_bytes   in   table_byte, final_byte
// roles         out  byte_role, area_offset, string_number, struct_type,
//                    struct_handle, struct_length, header_ok, struct_done,
//                    struct_cut, corrupt_stop, table_end
//
// One beat per cycle sustained while roles is ready. Each byte goes through
// one input register, then the phase update into the result register, to its
// result beat. rst (synchronous) clears the parse state and both valid flags.
// A stall on roles holds the result register; table_bytes keeps taking beats
// while the input register can move forward in the same cycle.
module smbios_structure_framer
  import sbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sbf_byte_if.sink   table_bytes,
  sbf_role_if.source roles
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_final;
  logic         out_valid;
  result_t      out_res;
  parse_state_t state;
  parse_state_t state_next;
  result_t      res_next;
  logic         out_free;
  logic         advance;

  assign out_free          = !out_valid || roles.ready;
  assign advance           = in_valid && out_free;
  assign table_bytes.ready = !in_valid || out_free;

  sbf_step u_step (
    .cur        (state),
    .table_byte (in_byte),
    .final_byte (in_final),
    .nxt        (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (table_bytes.ready) begin
      in_valid <= table_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (table_bytes.ready && table_bytes.valid) begin
      in_byte  <= table_bytes.table_byte;
      in_final <= table_bytes.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign roles.valid         = out_valid;
  assign roles.byte_role     = out_res.byte_role;
  assign roles.area_offset   = out_res.area_offset;
  assign roles.string_number = out_res.string_number;
  assign roles.struct_type   = out_res.struct_type;
  assign roles.struct_handle = out_res.struct_handle;
  assign roles.struct_length = out_res.struct_length;
  assign roles.header_ok     = out_res.header_ok;
  assign roles.struct_done   = out_res.struct_done;
  assign roles.struct_cut    = out_res.struct_cut;
  assign roles.corrupt_stop  = out_res.corrupt_stop;
  assign roles.table_end     = out_res.table_end;

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    advance && in_final |=> state == STATE_RESET)
    else $error("parse state not cleared after final beat");

  a_done_role: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.struct_done |-> out_res.byte_role == ROLE_TERM)
    else $error("struct_done without set terminator");

  a_end_implies_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.table_end |-> out_res.struct_done)
    else $error("table_end without struct_done");

  a_stop_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.corrupt_stop && (out_res.struct_cut || out_res.struct_done)))
    else $error("corrupt_stop together with another outcome");

  a_stopped_state: assert property (@(posedge clk) disable iff (rst)
    advance && !in_final && (res_next.struct_cut || res_next.corrupt_stop)
    |=> state.phase == PH_STOP)
    else $error("stop not taken after cut or corrupt beat");

endmodule
`default_nettype wire

// File: tb/smbios_structure_framer_test.sv
`timescale 1ns / 100ps
module smbios_structure_framer_test;
  import sbf_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    result_t    want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  sbf_byte_if in_if ();
  sbf_role_if out_if ();

  smbios_structure_framer dut (
    .clk         (clk),
    .rst         (rst),
    .table_bytes (in_if),
    .roles       (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  phase_t      cur_phase;
  logic [7:0]  area_cnt;
  logic [7:0]  hold_len;
  logic [7:0]  hold_type;
  logic [15:0] hold_handle;
  logic [7:0]  str_cnt;

  result_t    pending_roles[$];
  logic [7:0] table_q[$];
  int         bytes_sent = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  bit         src_calm = 1'b0;
  bit         sink_calm = 1'b0;
  bit         long_hold_done = 1'b0;

  step_row_t plan[26] = '{
    '{8'hFF, 1'b0, 1'b1,
      '{ROLE_FMT, 8'd0, 8'd0, 8'hFF, 16'h0000, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'h00, 1'b0, 1'b1,
      '{ROLE_FMT, 8'd1, 8'd0, 8'hFF, 16'h0000, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'h34, 1'b0, 1'b1,
      '{ROLE_FMT, 8'd2, 8'd0, 8'hFF, 16'h0034, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'h12, 1'b0, 1'b1,
      '{ROLE_FMT, 8'd3, 8'd0, 8'hFF, 16'h1234, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{8'hAB, 1'b1, 1'b1,
      '{ROLE_IGN, 8'd0, 8'd0, 8'hFF, 16'h1234, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h06, 1'b1, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h05, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0}
  };

  function automatic void clear_framer();
    cur_phase   = PH_HDR;
    area_cnt    = 8'd0;
    hold_len    = 8'd0;
    hold_type   = 8'd0;
    hold_handle = 16'd0;
    str_cnt     = 8'd0;
  endfunction

  function automatic result_t frame_byte(input logic [7:0] b, input logic fin);
    result_t    r;
    role_t      role;
    logic [7:0] off;
    logic       hok, done, cut, corr, tend;
    role = ROLE_IGN;
    off  = 8'd0;
    hok  = 1'b0;
    done = 1'b0;
    cut  = 1'b0;
    corr = 1'b0;
    tend = 1'b0;
    case (cur_phase)
      PH_HDR: begin
        role = ROLE_FMT;
        off  = area_cnt;
        if (area_cnt == 8'd0) begin
          hold_type   = b;
          hold_len    = 8'd0;
          hold_handle = 16'd0;
          str_cnt     = 8'd0;
        end else if (area_cnt == 8'd1) begin
          hold_len = b;
        end else if (area_cnt == 8'd2) begin
          hold_handle = {8'h00, b};
        end else begin
          hold_handle = {b, hold_handle[7:0]};
        end
        if (area_cnt < HDR_SIZE - 8'd1) begin
          area_cnt = area_cnt + 8'd1;
        end else if (hold_len < HDR_SIZE) begin
          corr = 1'b1;
        end else if (hold_len == HDR_SIZE) begin
          hok       = 1'b1;
          cur_phase = PH_SEC;
          cut       = fin;
        end else begin
          area_cnt  = HDR_SIZE;
          cur_phase = PH_AREA;
          corr      = fin;
        end
      end
      PH_AREA: begin
        role     = ROLE_FMT;
        off      = area_cnt;
        area_cnt = area_cnt + 8'd1;
        if (area_cnt == hold_len) begin
          hok       = 1'b1;
          cur_phase = PH_SEC;
          cut       = fin;
        end else begin
          corr = fin;
        end
      end
      PH_SEC: begin
        str_cnt = 8'd1;
        if (b == 8'd0) begin
          role      = ROLE_LEAD;
          cur_phase = PH_LEAD;
        end else begin
          role      = ROLE_TEXT;
          cur_phase = PH_STR;
        end
        cut = fin;
      end
      PH_LEAD: begin
        if (b == 8'd0) begin
          role    = ROLE_TERM;
          str_cnt = 8'd0;
          done    = 1'b1;
        end else begin
          role      = ROLE_TEXT;
          str_cnt   = 8'd2;
          cur_phase = PH_STR;
          cut       = fin;
        end
      end
      PH_STR: begin
        if (b == 8'd0) begin
          role      = ROLE_NUL;
          cur_phase = PH_NUL;
        end else begin
          role = ROLE_TEXT;
        end
        cut = fin;
      end
      PH_NUL: begin
        if (b == 8'd0) begin
          role = ROLE_TERM;
          done = 1'b1;
        end else begin
          role = ROLE_TEXT;
          if (str_cnt != 8'hFF) str_cnt = str_cnt + 8'd1;
          cur_phase = PH_STR;
          cut       = fin;
        end
      end
      default: role = ROLE_IGN;
    endcase
    if (done) begin
      tend     = (hold_type == END_TYPE);
      area_cnt = 8'd0;
      if (tend) cur_phase = PH_STOP;
      else cur_phase = PH_HDR;
    end
    if (cut || corr) cur_phase = PH_STOP;
    r = '{byte_role: role, area_offset: off, string_number: str_cnt,
          struct_type: hold_type, struct_handle: hold_handle, struct_length: hold_len,
          header_ok: hok, struct_done: done, struct_cut: cut, corrupt_stop: corr,
          table_end: tend};
    if (fin) clear_framer();
    return r;
  endfunction

  function automatic string role_text(input result_t r);
    return $sformatf("role %0d off %0d str %0d type %h handle %h len %0d flags %b%b%b%b%b",
                     r.byte_role, r.area_offset, r.string_number, r.struct_type,
                     r.struct_handle, r.struct_length, r.header_ok, r.struct_done,
                     r.struct_cut, r.corrupt_stop, r.table_end);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic table_add(input logic [7:0] b);
    table_q.insert(table_q.size(), b);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input result_t want);
    int      gap;
    result_t predicted;
    if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
    gap = (src_calm || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.table_byte <= b;
    in_if.final_byte <= fin;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
    predicted = frame_byte(b, fin);
    pending_roles.insert(pending_roles.size(), typed ? want : predicted);
  endtask

  task automatic send_table();
    foreach (table_q[i]) send_byte(table_q[i], i == table_q.size() - 1, 1'b0, '0);
  endtask

  task automatic append_structure(input int nstr);
    logic [7:0] len;
    int         r, slen;
    r = $urandom_range(0, 99);
    table_add((r < 8) ? END_TYPE : 8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 6) len = 8'($urandom_range(0, 3));
    else if (r == 6) len = 8'hFF;
    else if (r < 12) len = HDR_SIZE;
    else len = 8'($urandom_range(5, 16));
    table_add(len);
    table_add(8'($urandom_range(0, 255)));
    table_add(8'($urandom_range(0, 255)));
    for (int i = 4; i < len; i++) table_add(8'($urandom_range(0, 255)));
    if (nstr > 0 && $urandom_range(0, 3) == 0) table_add(8'h00);
    for (int s = 0; s < nstr; s++) begin
      slen = $urandom_range(1, 6);
      repeat (slen) table_add(8'($urandom_range(1, 255)));
      table_add(8'h00);
    end
    table_add(8'h00);
  endtask

  initial begin
    int kind, n;
    rst              = 1'b1;
    in_if.valid      = 1'b0;
    in_if.table_byte = 8'd0;
    in_if.final_byte = 1'b0;
    clear_framer();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_byte(plan[i].b, plan[i].fin, plan[i].typed, plan[i].want);

    // saturate the string number
    table_q = {};
    table_add(8'h02);
    table_add(HDR_SIZE);
    table_add(8'h00);
    table_add(8'h01);
    repeat (258) begin
      table_add(8'h61);
      table_add(8'h00);
    end
    table_add(8'h00);
    send_table();

    while (bytes_sent < 1060) begin
      table_q = {};
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        n = $urandom_range(1, 5);
        repeat (n) append_structure($urandom_range(0, 4));
        if (kind >= 65) begin
          n = $urandom_range(1, table_q.size());
          while (table_q.size() > n) void'(table_q.pop_back());
        end
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) table_add($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
      end
      send_table();
    end
    in_if.valid <= 1'b0;

    while (pending_roles.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_roles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && bytes_sent >= 400) begin
        // hold off long enough for the block to fill and stall its input
        long_hold_done = 1'b1;
        hold = 299;
        out_if.ready <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 99) < 30) begin
        hold = gap_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_roles
    result_t got, want;
    if (!rst && out_if.valid && out_if.ready) begin
      got = '{byte_role: out_if.byte_role, area_offset: out_if.area_offset,
              string_number: out_if.string_number, struct_type: out_if.struct_type,
              struct_handle: out_if.struct_handle, struct_length: out_if.struct_length,
              header_ok: out_if.header_ok, struct_done: out_if.struct_done,
              struct_cut: out_if.struct_cut, corrupt_stop: out_if.corrupt_stop,
              table_end: out_if.table_end};
      if (pending_roles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %s", role_text(got));
      end else begin
        want = pending_roles.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch expected: %s", role_text(want));
            $display("         actual:   %s", role_text(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= 5000) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
